[hw/rtl/sobel_edge_block_classifier_core_assert.svh]
// Assertion macros for the Sobel edge block classifier.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef SOBEL_EDGE_BLOCK_CLASSIFIER_CORE_ASSERT_SVH
`define SOBEL_EDGE_BLOCK_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SEBC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sebc assertion failed");

// Next-cycle implication.
`define SEBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sebc assertion failed");

`endif

[hw/rtl/sebc_pkg.sv]
// Shared types, codes and constants of the Sobel edge block classifier.
// No dependencies; used by every module of the block.
package sebc_pkg;

	localparam int PIX_W          = 12;
	localparam int GRAD_W         = 16;  // signed Sobel gradient
	localparam int GSQ_W          = 28;  // gradient squared
	localparam int ABS_SUM_W      = 15;  // |gx|+|gy| of one window
	localparam int TALLY_W        = 14;
	localparam int GSUM_W         = 29;
	localparam int MSUM_W         = 30;
	localparam int PCT_W          = 7;
	localparam int DEPTH_W        = 4;
	localparam int THR_W          = 18;  // squared threshold
	localparam int PROD_W         = 21;  // tally times percent
	localparam int MIN_PIXEL_BITS = 8;
	localparam int MAX_PIXEL_BITS = 12;

	localparam logic [THR_W-1:0]   THR_BASE_SQ = 18'd900;  // 30 squared
	localparam logic [PROD_W-1:0]  PCT_SCALE   = 21'd100;

	typedef enum logic [2:0] {
		CLASS_FLAT             = 3'd0,
		CLASS_NORMAL           = 3'd1,
		CLASS_TEXTURE          = 3'd2,
		CLASS_CONTOUR_MIXED    = 3'd3,
		CLASS_CONTOUR_COHERENT = 3'd4
	} class_t;

	typedef enum logic [1:0] {
		CFG_PIXEL_BIT_DEPTH = 2'd0,
		CFG_HIGH_DENSITY    = 2'd1,
		CFG_MEDIUM_DENSITY  = 2'd2,
		CFG_LOW_DENSITY     = 2'd3
	} cfg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t tl;
		pix_t tm;
		pix_t tr;
		pix_t ml;
		pix_t mr;
		pix_t bl;
		pix_t bm;
		pix_t br;
		logic incl;
		logic last;
	} window_t;

	typedef struct packed {
		logic [GSQ_W-1:0]        gx_sq;
		logic [GSQ_W-1:0]        gy_sq;
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic [ABS_SUM_W-1:0]    abs_sum;
		logic                    incl;
		logic                    last;
	} grad_t;

	typedef struct packed {
		logic [TALLY_W-1:0] edge_tally;
		logic [TALLY_W-1:0] pos_tally;
		logic [GSUM_W-1:0]  hsum;
		logic [GSUM_W-1:0]  vsum;
		logic [MSUM_W-1:0]  msum;
	} snap_t;

	typedef struct packed {
		logic [TALLY_W-1:0] edge_tally;
		logic [TALLY_W-1:0] pos_tally;
	} tally_t;

	typedef struct packed {
		logic [PCT_W-1:0] high;
		logic [PCT_W-1:0] med;
		logic [PCT_W-1:0] low;
	} pct_t;

	// Squared edge threshold: (30 << (depth - 8))^2, depth clamped to 8..12.
	function automatic logic [THR_W-1:0] thr_sq(input logic [DEPTH_W-1:0] depth);
		logic [DEPTH_W-1:0] d;
		logic [2:0]         sh;
		if (depth < DEPTH_W'(MIN_PIXEL_BITS)) begin
			d = DEPTH_W'(MIN_PIXEL_BITS);
		end else if (depth > DEPTH_W'(MAX_PIXEL_BITS)) begin
			d = DEPTH_W'(MAX_PIXEL_BITS);
		end else begin
			d = depth;
		end
		sh = 3'(d - DEPTH_W'(MIN_PIXEL_BITS));
		return THR_BASE_SQ << {sh, 1'b0};
	endfunction

endpackage

[hw/rtl/sebc_gradient.sv]
// Three-stage Sobel front end: window register, gradients, squares.
// Depends on sebc_pkg.
module sebc_gradient (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sebc_pkg::window_t in_win,
	output logic             out_valid,
	input  logic             out_ready,
	output sebc_pkg::grad_t  out_grad
);

	logic              v_s1, v_s2, v_s3;
	logic              rdy1, rdy2, rdy3;
	sebc_pkg::window_t win_s1;
	logic signed [sebc_pkg::GRAD_W-1:0] gx_c, gy_c, gx_s2, gy_s2;
	logic              incl_s2, last_s2;
	sebc_pkg::grad_t   grad_c, grad_s3;
	logic signed [31:0] gxx_c, gyy_c;
	logic [sebc_pkg::GRAD_W-1:0] ax_c, ay_c;

	function automatic logic signed [sebc_pkg::GRAD_W-1:0] wide(input sebc_pkg::pix_t p);
		return $signed({4'b0000, p});
	endfunction

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		gx_c = wide(win_s1.tr) - wide(win_s1.tl) + ((wide(win_s1.mr) - wide(win_s1.ml)) <<< 1)
			+ wide(win_s1.br) - wide(win_s1.bl);
		gy_c = wide(win_s1.bl) - wide(win_s1.tl) + ((wide(win_s1.bm) - wide(win_s1.tm)) <<< 1)
			+ wide(win_s1.br) - wide(win_s1.tr);
	end

	always_comb begin
		gxx_c = gx_s2 * gx_s2;
		gyy_c = gy_s2 * gy_s2;
		ax_c  = gx_s2[sebc_pkg::GRAD_W-1] ? 16'(-gx_s2) : 16'(gx_s2);
		ay_c  = gy_s2[sebc_pkg::GRAD_W-1] ? 16'(-gy_s2) : 16'(gy_s2);
		grad_c.gx_sq   = gxx_c[sebc_pkg::GSQ_W-1:0];
		grad_c.gy_sq   = gyy_c[sebc_pkg::GSQ_W-1:0];
		grad_c.gx      = gx_s2;
		grad_c.gy      = gy_s2;
		grad_c.abs_sum = ax_c[sebc_pkg::ABS_SUM_W-2:0] + ay_c[sebc_pkg::ABS_SUM_W-2:0]
			+ sebc_pkg::ABS_SUM_W'(0);
		grad_c.incl    = incl_s2;
		grad_c.last    = last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) win_s1 <= in_win;
		if (rdy2 && v_s1) begin
			gx_s2   <= gx_c;
			gy_s2   <= gy_c;
			incl_s2 <= win_s1.incl;
			last_s2 <= win_s1.last;
		end
		if (rdy3 && v_s2) grad_s3 <= grad_c;
	end

	assign out_valid = v_s3;
	assign out_grad  = grad_s3;

endmodule

[hw/rtl/sebc_accum.sv]
// Block accumulators and the end-of-block snapshot register.
// Depends on sebc_pkg.
module sebc_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sebc_pkg::THR_W-1:0]    thr,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  sebc_pkg::grad_t               in_grad,
	output logic                          out_valid,
	input  logic                          out_ready,
	output sebc_pkg::snap_t               out_snap,
	output sebc_pkg::tally_t              tally
);

	sebc_pkg::snap_t acc_q, acc_n, snap_q;
	logic            snap_v_q;
	logic            snap_rdy;
	logic            fire;
	logic            is_edge;
	logic [sebc_pkg::GSQ_W:0] mag;

	assign snap_rdy = !snap_v_q || out_ready;
	// A window that closes a block needs the snapshot register free.
	assign in_ready = !in_grad.last || snap_rdy;
	assign fire     = in_valid && in_ready;

	always_comb begin
		mag     = {1'b0, in_grad.gx_sq} + {1'b0, in_grad.gy_sq};
		is_edge = in_grad.incl && (mag > (sebc_pkg::GSQ_W+1)'(thr));
		acc_n   = acc_q;
		if (in_grad.incl) begin
			acc_n.pos_tally = acc_q.pos_tally + 1'b1;
		end
		if (is_edge) begin
			acc_n.edge_tally = acc_q.edge_tally + 1'b1;
			acc_n.hsum = acc_q.hsum + sebc_pkg::GSUM_W'(in_grad.gx);
			acc_n.vsum = acc_q.vsum + sebc_pkg::GSUM_W'(in_grad.gy);
			acc_n.msum = acc_q.msum + sebc_pkg::MSUM_W'(in_grad.abs_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			snap_v_q <= 1'b0;
		end else begin
			if (fire) begin
				acc_q <= in_grad.last ? '0 : acc_n;
			end
			if (snap_rdy) snap_v_q <= fire && in_grad.last;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && in_grad.last) snap_q <= acc_n;
	end

	assign out_valid        = snap_v_q;
	assign out_snap         = snap_q;
	assign tally.edge_tally = acc_q.edge_tally;
	assign tally.pos_tally  = acc_q.pos_tally;

endmodule

[hw/rtl/sebc_classify.sv]
// Two-stage classifier: products of the snapshot, then the decision.
// Depends on sebc_pkg.
module sebc_classify (
	input  logic               clk,
	input  logic               arst_n,
	input  sebc_pkg::pct_t     pct,
	input  logic               in_valid,
	output logic               in_ready,
	input  sebc_pkg::snap_t    in_snap,
	output logic               out_valid,
	input  logic               out_ready,
	output sebc_pkg::class_t   out_class
);

	localparam int AX_W  = sebc_pkg::GSUM_W;
	localparam int AX2_W = 2 * AX_W;
	localparam int MS2_W = 2 * sebc_pkg::MSUM_W;

	logic v_s2, v_q;
	logic rdy2, rdy_o;
	logic [AX_W-1:0]  ax_c, ay_c;
	logic [AX2_W-1:0] ax2_c, ay2_c, ax2_s2, ay2_s2;
	logic [MS2_W-1:0] ms2_c, ms2_s2;
	logic [sebc_pkg::PROD_W-1:0] e100_s2, hp_s2, mp_s2, lp_s2;
	logic pzero_s2, msnz_s2;
	logic [AX2_W:0]   vec;
	logic             coherent;
	sebc_pkg::class_t cls_c, cls_q;

	assign rdy_o    = !v_q || out_ready;
	assign rdy2     = !v_s2 || rdy_o;
	assign in_ready = rdy2;

	always_comb begin
		ax_c  = in_snap.hsum[AX_W-1] ? (~in_snap.hsum + 1'b1) : in_snap.hsum;
		ay_c  = in_snap.vsum[AX_W-1] ? (~in_snap.vsum + 1'b1) : in_snap.vsum;
		ax2_c = AX2_W'(ax_c) * AX2_W'(ax_c);
		ay2_c = AX2_W'(ay_c) * AX2_W'(ay_c);
		ms2_c = MS2_W'(in_snap.msum) * MS2_W'(in_snap.msum);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && in_valid) begin
			ax2_s2   <= ax2_c;
			ay2_s2   <= ay2_c;
			ms2_s2   <= ms2_c;
			e100_s2  <= sebc_pkg::PROD_W'(in_snap.edge_tally) * sebc_pkg::PCT_SCALE;
			hp_s2    <= sebc_pkg::PROD_W'(pct.high) * sebc_pkg::PROD_W'(in_snap.pos_tally);
			mp_s2    <= sebc_pkg::PROD_W'(pct.med) * sebc_pkg::PROD_W'(in_snap.pos_tally);
			lp_s2    <= sebc_pkg::PROD_W'(pct.low) * sebc_pkg::PROD_W'(in_snap.pos_tally);
			pzero_s2 <= (in_snap.pos_tally == '0);
			msnz_s2  <= (in_snap.msum != '0);
		end
		if (rdy_o && v_s2) cls_q <= cls_c;
	end

	always_comb begin
		vec      = {1'b0, ax2_s2} + {1'b0, ay2_s2};
		coherent = msnz_s2 && ({vec, 2'b00} > (AX2_W+3)'(ms2_s2));
		if (pzero_s2) begin
			cls_c = sebc_pkg::CLASS_NORMAL;
		end else if (e100_s2 > hp_s2) begin
			cls_c = coherent ? sebc_pkg::CLASS_CONTOUR_COHERENT : sebc_pkg::CLASS_CONTOUR_MIXED;
		end else if (e100_s2 > mp_s2) begin
			cls_c = sebc_pkg::CLASS_TEXTURE;
		end else if (e100_s2 > lp_s2) begin
			cls_c = sebc_pkg::CLASS_NORMAL;
		end else begin
			cls_c = sebc_pkg::CLASS_FLAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (rdy2)  v_s2 <= in_valid;
			if (rdy_o) v_q  <= v_s2;
		end
	end

	assign out_valid = v_q;
	assign out_class = cls_q;

endmodule

[hw/rtl/sobel_edge_block_classifier_core.sv]
// Top level of the Sobel edge block classifier: config registers and the
// gradient, accumulator and classifier pipelines. Depends on sebc_pkg,
// sebc_gradient, sebc_accum, sebc_classify and the assertion macro header.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------
//  s_      | in  | s_tvalid / s_tready  | s_tdata 3x3 window, s_tuser incl, s_tlast
//  m_      | out | m_tvalid / m_tready  | m_tdata block class
//  cfg_    | in  | cfg_wr_en            | cfg_index, cfg_data
//
// One window word is taken every cycle while s_tready is high. A window passes
// three gradient stages (register, Sobel, squares) and is then folded into the
// accumulators; a block-closing word loads the snapshot on the edge that folds it,
// and the product and class registers follow it, after which its class shows on m_.
// With m_tready low, non-closing words keep flowing; s_ stalls once class, product
// and snapshot registers all hold a block, the next closing word reaches the
// accumulators and the gradient stages behind it are full.
// arst_n clears valid bits, accumulators and config registers (to their
// defaults); data registers are not reset.
`include "sobel_edge_block_classifier_core_assert.svh"

module sobel_edge_block_classifier_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// bits lowest up: pix_top_left, pix_top_mid, pix_top_right, pix_mid_left,
	// pix_center, pix_mid_right, pix_bottom_left, pix_bottom_mid,
	// pix_bottom_right (12 each), 4 zero pad bits
	input  logic [111:0] s_tdata,
	// include_position
	input  logic         s_tuser,
	// last_of_block
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// bits lowest up: block_class (3), 5 zero pad bits
	output logic [7:0]   m_tdata,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [6:0]   cfg_data
);

	logic [sebc_pkg::DEPTH_W-1:0] depth_q;
	sebc_pkg::pct_t               pct_q;
	logic [sebc_pkg::THR_W-1:0]   thr;

	sebc_pkg::window_t win;
	sebc_pkg::grad_t   grad;
	logic              grad_valid, grad_ready;
	sebc_pkg::snap_t   snap;
	logic              snap_valid, snap_ready;
	sebc_pkg::tally_t  tally;
	sebc_pkg::class_t  cls;

	// Config registers; the user must write them only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= 4'd8;
			pct_q.high <= 7'd18;
			pct_q.med  <= 7'd8;
			pct_q.low  <= 7'd3;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sebc_pkg::CFG_PIXEL_BIT_DEPTH: depth_q <= cfg_data[sebc_pkg::DEPTH_W-1:0];
				sebc_pkg::CFG_HIGH_DENSITY:    pct_q.high <= cfg_data;
				sebc_pkg::CFG_MEDIUM_DENSITY:  pct_q.med <= cfg_data;
				sebc_pkg::CFG_LOW_DENSITY:     pct_q.low <= cfg_data;
				default: ;
			endcase
		end
	end

	assign thr = sebc_pkg::thr_sq(depth_q);

	// Unpack the window word; the center sample is not used by Sobel.
	always_comb begin
		win.tl   = s_tdata[11:0];
		win.tm   = s_tdata[23:12];
		win.tr   = s_tdata[35:24];
		win.ml   = s_tdata[47:36];
		win.mr   = s_tdata[71:60];
		win.bl   = s_tdata[83:72];
		win.bm   = s_tdata[95:84];
		win.br   = s_tdata[107:96];
		win.incl = s_tuser;
		win.last = s_tlast;
	end

	sebc_gradient u_gradient (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_win    (win),
		.out_valid (grad_valid),
		.out_ready (grad_ready),
		.out_grad  (grad)
	);

	sebc_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.thr       (thr),
		.in_valid  (grad_valid),
		.in_ready  (grad_ready),
		.in_grad   (grad),
		.out_valid (snap_valid),
		.out_ready (snap_ready),
		.out_snap  (snap),
		.tally     (tally)
	);

	sebc_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.pct       (pct_q),
		.in_valid  (snap_valid),
		.in_ready  (snap_ready),
		.in_snap   (snap),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_class (cls)
	);

	assign m_tdata = {5'b00000, cls};

	// With the sink ready, every stage drains, so the input must be open.
	`SEBC_ASSERT_NOW(a_ready_chain, m_tready, s_tready)
	// Folding a block-closing word leaves the tallies cleared.
	`SEBC_ASSERT_NEXT(a_clear_on_close, grad_valid && grad_ready && grad.last, tally == '0)

endmodule
